/* rtl/sfr_pkg.sv */
// shared types, constants and crc helper for the sync frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_LO  = 3'd3,
    PH_CRC_HI  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  localparam logic [31:0] SYNC_WORD      = 32'h90EB90EB;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd1024;
  localparam int          HDR_BYTES      = 7;
  localparam logic [15:0] LEN_LO_INDEX   = 16'd7;
  localparam logic [15:0] LEN_HI_INDEX   = 16'd8;

  // one byte through the reflected crc-16/modbus shift register
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(input logic [1:0] k);
    return SYNC_WORD[8*k +: 8];
  endfunction

  // crc state after the four sync bytes, fixed at elaboration
  localparam logic [15:0] CRC_AFTER_SYNC =
    crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, SYNC_WORD[7:0]), SYNC_WORD[15:8]),
                      SYNC_WORD[23:16]), SYNC_WORD[31:24]);

endpackage

/* rtl/sync_frame_receiver_crc16.sv */
// sync word framed byte receiver with crc-16/modbus check
`timescale 1ns / 1ps

// channel   signals                          direction  beat
// rx        rx_valid rx_ready rx_byte          in       one received byte
// res       res_valid res_ready kind ... last  out      one payload byte or frame status
// cfg       cfg_write cfg_data                 in       max payload length, no handshake
//
// one byte is taken every cycle that rx_ready is high; its result, if any, sits in the result register
// the next cycle. rx_ready is high while the result register is empty or being
// drained, so a stalled res side holds the input only when a result waits.
// rst is synchronous: phase back to sync hunt, result register emptied,
// max payload length back to 1024.

module sync_frame_receiver_crc16
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // received byte stream
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  // results
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  source_type,
  output logic [7:0]  dst_type,
  output logic [15:0] source_address,
  output logic [15:0] dest_address,
  output logic [7:0]  function_code,
  output logic [15:0] payload_length,
  output logic        last,
  // configuration
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  // frame state
  phase_t      phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  hdr_bytes [HDR_BYTES];
  logic [15:0] length_store, length_store_next;
  logic [7:0]  crc_low_byte;
  logic [15:0] max_len;

  logic        rx_fire;
  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic        too_long;
  logic [2:0]  hunt_k;
  logic        hdr_wr;
  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_data;

  // result register drains or is empty: take the next byte
  assign rx_ready = !res_valid || res_ready;
  assign rx_fire  = rx_valid && rx_ready;

  assign crc_upd  = crc_feed(running_crc, rx_byte);
  assign cnt_inc  = byte_counter + 16'd1;
  assign len_full = {rx_byte, length_store[7:0]};
  assign too_long = len_full > max_len;

  // sliding sync match, only the EB byte can restart a broken match
  always_comb begin
    if (rx_byte == sync_byte(byte_counter[1:0])) begin
      hunt_k = {1'b0, byte_counter[1:0]} + 3'd1;
    end else if (rx_byte == sync_byte(2'd0)) begin
      hunt_k = 3'd1;
    end else begin
      hunt_k = 3'd0;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (byte_counter >= LEN_HI_INDEX) begin
          if (too_long) begin
            phase_next = PH_HUNT;
          end else if (len_full == 16'd0) begin
            phase_next = PH_CRC_LO;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (cnt_inc >= length_store) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: phase_next = PH_CRC_HI;
      PH_CRC_HI: phase_next = PH_HUNT;
      default: begin
        phase_next = (hunt_k == 3'd4) ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  // counter, crc, length and header write per phase
  always_comb begin
    byte_counter_next = byte_counter;
    running_crc_next  = running_crc;
    length_store_next = length_store;
    hdr_wr            = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        running_crc_next = crc_upd;
        if (byte_counter < LEN_LO_INDEX) begin
          hdr_wr            = 1'b1;
          byte_counter_next = cnt_inc;
        end else if (byte_counter == LEN_LO_INDEX) begin
          length_store_next = {8'h00, rx_byte};
          byte_counter_next = LEN_HI_INDEX;
        end else begin
          length_store_next = len_full;
          byte_counter_next = 16'd0;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next  = crc_upd;
        byte_counter_next = (cnt_inc >= length_store) ? 16'd0 : cnt_inc;
      end
      PH_CRC_LO: ;
      PH_CRC_HI: byte_counter_next = 16'd0;
      default: begin
        if (hunt_k == 3'd4) begin
          running_crc_next  = CRC_AFTER_SYNC;
          byte_counter_next = 16'd0;
          length_store_next = 16'd0;
        end else begin
          byte_counter_next = {13'd0, hunt_k};
        end
      end
    endcase
  end

  // result produced by this byte, if any
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_DATA;
    emit_data = 8'h00;
    unique case (phase)
      PH_HEADER: begin
        if (byte_counter >= LEN_HI_INDEX && too_long) begin
          emit      = 1'b1;
          emit_kind = KIND_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        emit_kind = KIND_DATA;
        emit_data = rx_byte;
      end
      PH_CRC_HI: begin
        emit      = 1'b1;
        emit_kind = ({rx_byte, crc_low_byte} == running_crc) ? KIND_GOOD : KIND_CRC_ERR;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_counter <= 16'd0;
      running_crc  <= CRC_INIT;
      length_store <= 16'd0;
      crc_low_byte <= 8'h00;
      max_len      <= MAX_LEN_RESET;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      if (rx_fire) begin
        phase        <= phase_next;
        byte_counter <= byte_counter_next;
        running_crc  <= running_crc_next;
        length_store <= length_store_next;
        if (phase == PH_CRC_LO) begin
          crc_low_byte <= rx_byte;
        end
      end
      if (rx_fire) begin
        res_valid <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // header bytes, cleared when the sync word completes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_bytes[i] <= 8'h00;
      end
    end else if (rx_fire) begin
      if (phase == PH_HUNT && hunt_k == 3'd4) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr_bytes[i] <= 8'h00;
        end
      end else if (phase == PH_HEADER && hdr_wr) begin
        hdr_bytes[byte_counter[2:0]] <= rx_byte;
      end
    end
  end

  // result register, loaded with the fields as they stand after this byte
  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      kind           <= emit_kind;
      data_byte      <= emit_data;
      source_type    <= hdr_bytes[0];
      dst_type       <= hdr_bytes[1];
      source_address <= {hdr_bytes[3], hdr_bytes[2]};
      dest_address   <= {hdr_bytes[5], hdr_bytes[4]};
      function_code  <= hdr_bytes[6];
      payload_length <= length_store_next;
      last           <= (emit_kind != KIND_DATA);
    end
  end

endmodule
